// ===== sv/pate_pkg.sv =====
// ----------------------------------------------------------------------------
// pate_pkg: shared types and constants
// Field widths, command codes and sequencer states for the transform engine.
// ----------------------------------------------------------------------------
package pate_pkg;

   localparam int MAX_VERTICES = 6;
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = 3;
   localparam logic [CNT_W-1:0] COUNT_RESET = 3'd4;
   // last step of the centroid divider: 19 quotient bits
   localparam logic [4:0] DIV_LAST = 5'd18;

   typedef enum logic [2:0] {
      MODE_LOAD      = 3'd0,
      MODE_READ      = 3'd1,
      MODE_TRANSLATE = 3'd2,
      MODE_ROTATE    = 3'd3,
      MODE_SCALE     = 3'd4,
      MODE_SHEAR     = 3'd5,
      MODE_REFLECT   = 3'd6,
      MODE_NONE      = 3'd7
   } mode_type;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_SUM    = 11'b00000000010,
      ST_DIVX   = 11'b00000000100,
      ST_DIVY   = 11'b00000001000,
      ST_FETCH  = 11'b00000010000,
      ST_MUL1   = 11'b00000100000,
      ST_MUL2   = 11'b00001000000,
      ST_MUL3   = 11'b00010000000,
      ST_MUL4   = 11'b00100000000,
      ST_WRITE  = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v,
                                                output logic ovf);
      ovf = 1'b0;
      if (v > 36'sd32767) begin
         ovf = 1'b1;
         sat16 = 16'sh7fff;
      end else if (v < -36'sd32768) begin
         ovf = 1'b1;
         sat16 = -16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

endpackage

// ===== sv/polygon_affine_transform_engine_core.sv =====
// ----------------------------------------------------------------------------
// polygon_affine_transform_engine_core
// Vertex store with load, read and affine transforms in Q8.8 / Q4.12.
// ----------------------------------------------------------------------------
// One command at a time. Load, read, the unused code and any transform with a
// vertex count of 0 go from the accepting state straight to the done state.
// With n vertices in use a translate or reflect fetches and writes back each
// vertex, a scale or shear uses one shared 18x16 multiplier twice per vertex,
// and a rotate first forms the centroid sum over the n vertices, then runs two
// restoring divisions by n (one quotient bit per cycle), then forms four
// products per vertex before each write-back. The result waits in an output
// register; the next command is taken the cycle after it has been transferred.
module polygon_affine_transform_engine_core
   import pate_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [2:0]         req_vertex_index,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_factor_a,
   input  logic signed [15:0] req_factor_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_vertex_x,
   output logic signed [15:0] rsp_vertex_y,
   output logic               rsp_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_vertex_count
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [15:0] xs_ff [MAX_VERTICES];
   logic signed [15:0] ys_ff [MAX_VERTICES];
   mode_type mode_ff;
   logic signed [15:0] cx_ff, cy_ff, a_ff, b_ff;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] n_ff;
   logic signed [18:0] sx_ff, sy_ff;
   // divider: magnitude remainder/quotient
   logic [18:0] dq_ff, dq_in;
   logic [CNT_W:0] drem_ff, drem_in;
   logic [4:0] dcnt_ff, dcnt_in;
   logic signed [15:0] cenx_ff, ceny_ff;
   logic signed [17:0] px_ff, py_ff;  // vertex operands (dx, dy or x, y)
   logic signed [35:0] acc_ff;
   logic signed [35:0] accx_ff;
   logic ovf_ff;
   logic signed [15:0] ox_ff, oy_ff;
   logic rv_ff;

   assign req_ready = state_ff == ST_IDLE && !rv_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_vertex_x = ox_ff;
   assign rsp_vertex_y = oy_ff;
   assign rsp_overflow = ovf_ff;

   wire req_xfer = req_valid && req_ready;
   wire req_xform = req_mode == MODE_TRANSLATE || req_mode == MODE_ROTATE ||
                    req_mode == MODE_SCALE || req_mode == MODE_SHEAR ||
                    req_mode == MODE_REFLECT;
   wire last = {1'b0, ptr_ff} + 4'd1 >= {1'b0, n_ff};

   // shared multiplier operands
   logic signed [17:0] mop1;
   logic signed [15:0] mop2;
   logic signed [33:0] prod;
   assign prod = mop1 * mop2;

   // rotate: dx*a, dy*b, dx*b, dy*a over MUL1..MUL4
   always_comb begin
      mop1 = px_ff;
      mop2 = a_ff;
      unique case (mode_ff)
         MODE_ROTATE: begin
            mop1 = (state_ff == ST_MUL1 || state_ff == ST_MUL3) ? px_ff : py_ff;
            mop2 = (state_ff == ST_MUL1 || state_ff == ST_MUL4) ? a_ff : b_ff;
         end
         MODE_SCALE: begin
            mop1 = state_ff == ST_MUL1 ? px_ff : py_ff;
            mop2 = state_ff == ST_MUL1 ? a_ff : b_ff;
         end
         MODE_SHEAR: begin
            mop1 = state_ff == ST_MUL1 ? py_ff : px_ff;
            mop2 = state_ff == ST_MUL1 ? a_ff : b_ff;
         end
         default: begin
            mop1 = px_ff;
            mop2 = a_ff;
         end
      endcase
   end

   // division step: |sum| / n, then sign restore (truncate toward zero)
   logic [CNT_W+1:0] dtrial;
   assign dtrial = {drem_ff, dq_ff[18]} - {2'b00, n_ff};

   always_comb begin
      dq_in = {dq_ff[17:0], 1'b0};
      drem_in = drem_ff;
      if (dtrial[CNT_W+1]) begin
         drem_in = {drem_ff[CNT_W-1:0], dq_ff[18]};
      end else begin
         drem_in = dtrial[CNT_W:0];
         dq_in[0] = 1'b1;
      end
   end

   assign dcnt_in = ((state_ff == ST_DIVX || state_ff == ST_DIVY) && dcnt_ff != DIV_LAST) ?
                    dcnt_ff + 5'd1 : 5'd0;

   logic signed [35:0] newx, newy, prod_s;
   logic ox_sat, oy_sat;
   logic signed [15:0] wx, wy;
   assign prod_s = 36'(prod);

   always_comb begin
      newx = 36'(xs_ff[ptr_ff]);
      newy = 36'(ys_ff[ptr_ff]);
      unique case (mode_ff)
         MODE_TRANSLATE: begin
            newx = 36'(xs_ff[ptr_ff]) + 36'(cx_ff);
            newy = 36'(ys_ff[ptr_ff]) + 36'(cy_ff);
         end
         MODE_ROTATE: begin
            newx = 36'(cenx_ff) + (accx_ff >>> 12);
            newy = 36'(ceny_ff) + (acc_ff >>> 12);
         end
         MODE_SCALE: begin
            newx = accx_ff >>> 12;
            newy = acc_ff >>> 12;
         end
         MODE_SHEAR: begin
            newx = 36'(xs_ff[ptr_ff]) + (accx_ff >>> 12);
            newy = 36'(ys_ff[ptr_ff]) + (acc_ff >>> 12);
         end
         MODE_REFLECT: newx = -36'(xs_ff[ptr_ff]);
         default: ;
      endcase
      wx = sat16(newx, ox_sat);
      wy = sat16(newy, oy_sat);
      if (mode_ff == MODE_REFLECT) begin
         wy = ys_ff[ptr_ff];
         oy_sat = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) begin
            ptr_in = '0;
            if (req_xform && count_ff != '0)
               state_in = req_mode == MODE_ROTATE ? ST_SUM : ST_FETCH;
            else
               state_in = ST_DONE;
         end
         ST_SUM: begin
            ptr_in = ptr_ff + IDX_W'(1);
            if (last) state_in = ST_DIVX;
         end
         ST_DIVX: if (dcnt_ff == DIV_LAST) state_in = ST_DIVY;
         ST_DIVY: if (dcnt_ff == DIV_LAST) begin
            state_in = ST_FETCH;
            ptr_in = '0;
         end
         ST_FETCH: state_in = mode_ff == MODE_TRANSLATE || mode_ff == MODE_REFLECT ?
                              ST_WRITE : ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = mode_ff == MODE_ROTATE ? ST_MUL3 : ST_WRITE;
         ST_MUL3: state_in = ST_MUL4;
         ST_MUL4: state_in = ST_WRITE;
         ST_WRITE: begin
            ptr_in = ptr_ff + IDX_W'(1);
            state_in = last ? ST_DONE : ST_FETCH;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign count_in = csr_valid ? csr_vertex_count : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_RESET;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_DONE) rv_ff <= 1'b1;
         else if (rv_ff && rsp_ready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      dcnt_ff <= dcnt_in;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) begin
            mode_ff <= mode_type'(req_mode);
            cx_ff <= req_coord_x;
            cy_ff <= req_coord_y;
            a_ff <= req_factor_a;
            b_ff <= req_factor_b;
            n_ff <= count_ff > CNT_W'(MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : count_ff;
            sx_ff <= '0;
            sy_ff <= '0;
            ovf_ff <= 1'b0;
            if (req_mode == MODE_LOAD && 32'(req_vertex_index) < MAX_VERTICES) begin
               xs_ff[IDX_W'(req_vertex_index)] <= req_coord_x;
               ys_ff[IDX_W'(req_vertex_index)] <= req_coord_y;
            end
            if (req_mode == MODE_READ && 32'(req_vertex_index) < MAX_VERTICES) begin
               ox_ff <= xs_ff[IDX_W'(req_vertex_index)];
               oy_ff <= ys_ff[IDX_W'(req_vertex_index)];
            end else begin
               ox_ff <= '0;
               oy_ff <= '0;
            end
         end
         ST_SUM: begin
            sx_ff <= sx_ff + 19'(xs_ff[ptr_ff]);
            sy_ff <= sy_ff + 19'(ys_ff[ptr_ff]);
            dq_ff <= (sx_ff + 19'(xs_ff[ptr_ff])) < 0 ?
                     19'(-(sx_ff + 19'(xs_ff[ptr_ff]))) : 19'(sx_ff + 19'(xs_ff[ptr_ff]));
            drem_ff <= '0;
         end
         ST_DIVX, ST_DIVY: begin
            if (dcnt_ff == DIV_LAST) begin
               drem_ff <= '0;
               if (state_ff == ST_DIVX) begin
                  cenx_ff <= 16'(sx_ff[18] ? -$signed(dq_in) : $signed(dq_in));
                  dq_ff <= sy_ff[18] ? 19'(-sy_ff) : sy_ff;
               end else begin
                  ceny_ff <= 16'(sy_ff[18] ? -$signed(dq_in) : $signed(dq_in));
                  dq_ff <= dq_in;
               end
            end else begin
               dq_ff <= dq_in;
               drem_ff <= drem_in;
            end
         end
         ST_FETCH: begin
            if (mode_ff == MODE_ROTATE) begin
               px_ff <= 18'(xs_ff[ptr_ff]) - 18'(cenx_ff);
               py_ff <= 18'(ys_ff[ptr_ff]) - 18'(ceny_ff);
            end else begin
               px_ff <= 18'(xs_ff[ptr_ff]);
               py_ff <= 18'(ys_ff[ptr_ff]);
            end
         end
         ST_MUL1: accx_ff <= prod_s;
         ST_MUL2: begin
            if (mode_ff == MODE_ROTATE)
               accx_ff <= accx_ff - prod_s;
            else
               acc_ff <= prod_s;
         end
         ST_MUL3: acc_ff <= prod_s;
         ST_MUL4: acc_ff <= acc_ff + prod_s;
         ST_WRITE: begin
            xs_ff[ptr_ff] <= wx;
            ys_ff[ptr_ff] <= wy;
            ovf_ff <= ovf_ff | ox_sat | oy_sat;
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/pate_checker.sv =====
// ----------------------------------------------------------------------------
// pate_checker
// Port-level checks for the transform engine, bound to the top level.
// ----------------------------------------------------------------------------
module pate_checker
   import pate_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_mode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_vertex_x,
   input logic signed [15:0] rsp_vertex_y,
   input logic               rsp_overflow
);

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");

   a_load_no_ovf: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_LOAD) |=> ##1
      (rsp_valid && !rsp_overflow && rsp_vertex_x == 0)) else $error("load result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_vertex_x))
      else $error("result dropped");

endmodule

bind polygon_affine_transform_engine_core pate_checker u_pate_checker (.*);

// ===== verif/polygon_affine_transform_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// polygon_affine_transform_engine_core_test
// Drives load, read and transform commands with random idling and back
// pressure, predicts every response from a local copy of the vertex store
// and compares each response field by field.
// ----------------------------------------------------------------------------
module polygon_affine_transform_engine_core_test;
   import pate_pkg::*;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               ovf;
   } vertex_rsp_type;

   class vertex_scoreboard;
      logic signed [15:0] xs [MAX_VERTICES];
      logic signed [15:0] ys [MAX_VERTICES];
      int unsigned        count = COUNT_RESET;
      vertex_rsp_type     pending_rsp [$];
      int                 errors = 0;

      function void set_count(logic [2:0] v);
         count = v;
      endfunction

      function logic signed [15:0] clip(longint v, inout bit ovf);
         if (v > 32767) begin
            ovf = 1;
            return 16'sh7fff;
         end
         if (v < -32768) begin
            ovf = 1;
            return 16'sh8000;
         end
         return v[15:0];
      endfunction

      // one command in, one predicted response queued
      function void note_command(logic [2:0] m, logic [2:0] idx,
                                 logic signed [15:0] cx, logic signed [15:0] cy,
                                 logic signed [15:0] a, logic signed [15:0] b);
         vertex_rsp_type r;
         bit          ovf;
         int unsigned n;
         longint      sx, sy, mx, my, dx, dy, ox, oy;
         ovf = 0;
         r.x = 0;
         r.y = 0;
         n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
         case (mode_type'(m))
            MODE_LOAD: begin
               if (idx < MAX_VERTICES) begin
                  xs[idx] = cx;
                  ys[idx] = cy;
               end
            end
            MODE_READ: begin
               if (idx < MAX_VERTICES) begin
                  r.x = xs[idx];
                  r.y = ys[idx];
               end
            end
            MODE_TRANSLATE: begin
               for (int i = 0; i < n; i++) begin
                  xs[i] = clip(longint'(xs[i]) + cx, ovf);
                  ys[i] = clip(longint'(ys[i]) + cy, ovf);
               end
            end
            MODE_ROTATE: begin
               if (n > 0) begin
                  sx = 0;
                  sy = 0;
                  for (int i = 0; i < n; i++) begin
                     sx += xs[i];
                     sy += ys[i];
                  end
                  // centroid truncates toward zero
                  mx = sx / longint'(n);
                  my = sy / longint'(n);
                  for (int i = 0; i < n; i++) begin
                     dx = longint'(xs[i]) - mx;
                     dy = longint'(ys[i]) - my;
                     xs[i] = clip(mx + ((dx * a - dy * b) >>> 12), ovf);
                     ys[i] = clip(my + ((dx * b + dy * a) >>> 12), ovf);
                  end
               end
            end
            MODE_SCALE: begin
               for (int i = 0; i < n; i++) begin
                  xs[i] = clip((longint'(xs[i]) * a) >>> 12, ovf);
                  ys[i] = clip((longint'(ys[i]) * b) >>> 12, ovf);
               end
            end
            MODE_SHEAR: begin
               for (int i = 0; i < n; i++) begin
                  ox = xs[i];
                  oy = ys[i];
                  xs[i] = clip(ox + ((longint'(a) * oy) >>> 12), ovf);
                  ys[i] = clip(oy + ((longint'(b) * ox) >>> 12), ovf);
               end
            end
            MODE_REFLECT: begin
               for (int i = 0; i < n; i++)
                  xs[i] = clip(-longint'(xs[i]), ovf);
            end
            default: ;
         endcase
         r.ovf = ovf;
         pending_rsp.push_back(r);
      endfunction

      function void check_result(logic signed [15:0] x, logic signed [15:0] y,
                                 logic ovf);
         vertex_rsp_type e;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected response x=%0d y=%0d ovf=%0b", $time, x, y, ovf);
            return;
         end
         e = pending_rsp.pop_front();
         if (x !== e.x) begin
            errors++;
            $display("%0t vertex_x expected %0d actual %0d", $time, e.x, x);
         end
         if (y !== e.y) begin
            errors++;
            $display("%0t vertex_y expected %0d actual %0d", $time, e.y, y);
         end
         if (ovf !== e.ovf) begin
            errors++;
            $display("%0t overflow expected %0b actual %0b", $time, e.ovf, ovf);
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [2:0]         req_mode = 0;
   logic [2:0]         req_vertex_index = 0;
   logic signed [15:0] req_coord_x = 0;
   logic signed [15:0] req_coord_y = 0;
   logic signed [15:0] req_factor_a = 0;
   logic signed [15:0] req_factor_b = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [15:0] rsp_vertex_x;
   logic signed [15:0] rsp_vertex_y;
   logic               rsp_overflow;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_vertex_count = 0;

   vertex_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_left = 0;
   longint cycles = 0;

   polygon_affine_transform_engine_core u_top (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_vertex_x, rsp_vertex_y, rsp_overflow);
   end

   task automatic send_command(mode_type m, logic [2:0] idx,
                               logic signed [15:0] cx, logic signed [15:0] cy,
                               logic signed [15:0] a, logic signed [15:0] b);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= m;
      req_vertex_index <= idx;
      req_coord_x      <= cx;
      req_coord_y      <= cy;
      req_factor_a     <= a;
      req_factor_b     <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_command(m, idx, cx, cy, a, b);
   endtask

   // register writes only once every response is back
   task automatic write_count(logic [2:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_valid        <= 1'b1;
      csr_vertex_count <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_count(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_value(bit narrow);
      if (narrow)
         return 16'($signed($urandom_range(0, 4095)) - 2048);
      return 16'($urandom);
   endfunction

   function automatic logic signed [15:0] pick_factor();
      if ($urandom_range(1))
         return 16'($urandom_range(2048, 6144));
      return 16'($urandom);
   endfunction

   task automatic send_random();
      int r;
      r = $urandom_range(99);
      if (r < 30)
         send_command(MODE_LOAD, 3'($urandom_range(7)), pick_value(1'($urandom_range(1))),
                      pick_value(1'($urandom_range(1))), 16'($urandom), 16'($urandom));
      else if (r < 50)
         send_command(MODE_READ, 3'($urandom_range(7)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
      else
         send_command(mode_type'($urandom_range(2, 7)), 3'($urandom_range(7)),
                      pick_value($urandom_range(3) != 0), pick_value($urandom_range(3) != 0),
                      pick_factor(), pick_factor());
   endtask

   initial begin
      logic [2:0] counts [8];
      counts = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fill the whole store before anything reads it
      write_count(3'd6);
      send_command(MODE_LOAD, 3'd0, 16'sh7fff, -16'sh8000, 16'sd0, 16'sd0);
      send_command(MODE_LOAD, 3'd1, -16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
      send_command(MODE_LOAD, 3'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_command(MODE_LOAD, 3'd3, 16'sh0100, -16'sh0100, 16'sd0, 16'sd0);
      send_command(MODE_LOAD, 3'd4, 16'sh0001, -16'sh0001, 16'sd0, 16'sd0);
      send_command(MODE_LOAD, 3'd5, 16'sh5555, -16'sh5556, 16'sh7fff, -16'sh8000);
      for (int i = 0; i < 8; i++)
         send_command(MODE_READ, 3'(i), 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_command(MODE_LOAD, 3'd6, 16'sh1234, 16'sh1234, 16'sd0, 16'sd0);   // ignored
      send_command(MODE_LOAD, 3'd7, 16'sh1234, 16'sh1234, 16'sd0, 16'sd0);   // ignored
      send_command(MODE_NONE, 3'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      // min x saturates
      send_command(MODE_REFLECT, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_command(MODE_TRANSLATE, 3'd0, 16'sh0001, -16'sh0001, 16'sd0, 16'sd0);
      send_command(MODE_SCALE, 3'd0, 16'sd0, 16'sd0, 16'sh1000, -16'sh1000);
      send_command(MODE_SHEAR, 3'd0, 16'sd0, 16'sd0, 16'sh0800, -16'sh8000);
      send_command(MODE_ROTATE, 3'd0, 16'sd0, 16'sd0, 16'sh1000, 16'sh0000);
      send_command(MODE_ROTATE, 3'd0, 16'sd0, 16'sd0, -16'sh8000, 16'sh7fff);
      send_command(MODE_READ, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

      for (int seg = 0; seg < 8; seg++) begin
         write_count(counts[seg]);
         case (seg % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 64; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         if (seg == 4)
            hold_left = 400;   // fill the block while the sink holds off
         for (int k = 0; k < 112; k++)
            send_random();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
